[rtl/core/mcur_pkg.sv]
// Shared types, register codes and constants of the multi-channel ultrasonic ranger.
package mcur_pkg;

  localparam int MAX_LANES            = 8;
  localparam int NUM_CHANNELS_DEFAULT = 8;
  localparam int TICKS_PER_MS_DEFAULT = 1000;

  localparam int DIST_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  // trig (1) + ready mask (8) + eight distances (128) = 137, padded to bytes
  localparam int OUT_DATA_W = 144;

  localparam logic [TIME_W-1:0] PULSE_US = 32'd10;

  // floor(d * 1715 / 1000) == (d * DIST_MULT) >> DIST_SHIFT for every 16-bit d
  localparam int               DIST_SHIFT = 28;
  localparam int               PROD_W     = 45;
  localparam logic [28:0]      DIST_MULT  = 29'd460366808;

  localparam logic [3:0]        SENSOR_COUNT_RESET = 4'd0;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 16'd40000;
  localparam logic [15:0]       BURST_MS_RESET     = 16'd60;
  localparam logic [15:0]       MAX_ECHO_RESET     = 16'd23323;

  typedef enum logic [1:0] {
    REG_SENSOR_COUNT = 2'd0,
    REG_MAX_DISTANCE = 2'd1,
    REG_BURST_MS     = 2'd2,
    REG_MAX_ECHO     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [3:0]        sensor_count;
    logic [DIST_W-1:0] max_distance;
    logic [15:0]       burst_interval_ms;
    logic [15:0]       max_echo_us;
  } cfg_t;

  // accept: a tick request enters the first stage; move: it passes to the output register
  typedef struct packed {
    logic accept;
    logic move;
  } pipe_ctrl_t;

endpackage

[rtl/core/mcur_timer.sv]
// Microsecond and millisecond time base with the shared trigger pulse generator.
module mcur_timer import mcur_pkg::*; #(
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              run,
  input  logic [15:0]       burst_interval_ms,
  output logic [TIME_W-1:0] now_us,
  output logic              trig_next
);

  localparam int PW = $clog2(TICKS_PER_MS + 1);

  logic [TIME_W-1:0] us_time;
  logic [TIME_W-1:0] ms_time;
  logic [PW-1:0]     prescaler;
  logic              pulse_active;
  logic              pulse_active_next;
  logic [TIME_W-1:0] pulse_start;
  logic [TIME_W-1:0] pulse_start_next;
  logic [TIME_W-1:0] last_burst;
  logic [TIME_W-1:0] last_burst_next;
  logic [TIME_W-1:0] ms_gap;
  logic [TIME_W-1:0] us_gap;

  assign now_us = us_time;
  assign ms_gap = ms_time - last_burst;
  assign us_gap = us_time - pulse_start;

  always_comb begin
    pulse_active_next = pulse_active;
    pulse_start_next  = pulse_start;
    last_burst_next   = last_burst;
    if (run) begin
      if (!pulse_active) begin
        if (ms_gap >= {16'd0, burst_interval_ms}) begin
          pulse_active_next = 1'b1;
          pulse_start_next  = us_time;
        end
      end else if (us_gap >= PULSE_US) begin
        pulse_active_next = 1'b0;
        last_burst_next   = ms_time;
      end
    end
  end

  assign trig_next = pulse_active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      us_time      <= '0;
      ms_time      <= '0;
      prescaler    <= '0;
      pulse_active <= 1'b0;
      pulse_start  <= '0;
      last_burst   <= '0;
    end else if (accept) begin
      us_time      <= us_time + 1'b1;
      pulse_active <= pulse_active_next;
      pulse_start  <= pulse_start_next;
      last_burst   <= last_burst_next;
      if (prescaler == PW'(TICKS_PER_MS - 1)) begin
        prescaler <= '0;
        ms_time   <= ms_time + 1'b1;
      end else begin
        prescaler <= prescaler + 1'b1;
      end
    end
  end

endmodule

[rtl/core/mcur_lane.sv]
// One echo channel: edge detection, duration capture and distance conversion.
module mcur_lane import mcur_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctrl_t        ctrl,
  input  logic              level,
  input  logic              enable,
  input  logic [TIME_W-1:0] now_us,
  input  logic [DIST_W-1:0] max_distance,
  input  logic [15:0]       max_echo_us,
  output logic [DIST_W-1:0] distance,
  output logic              measured
);

  logic              prev_echo;
  logic              rise_seen;
  logic              rise_seen_next;
  logic [TIME_W-1:0] echo_start;
  logic [TIME_W-1:0] echo_start_next;
  logic              meas_next;
  logic              meas_q;
  logic [TIME_W-1:0] dur_q;
  logic [DIST_W-1:0] channel_distance;
  logic [PROD_W-1:0] prod;
  logic [16:0]       quot;
  logic              out_of_range;
  logic [DIST_W-1:0] new_dist;

  always_comb begin
    rise_seen_next  = rise_seen;
    echo_start_next = echo_start;
    meas_next       = 1'b0;
    if (enable && (level != prev_echo)) begin
      if (level) begin
        echo_start_next = now_us;
        rise_seen_next  = 1'b1;
      end else if (rise_seen) begin
        meas_next      = 1'b1;
        rise_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_echo  <= 1'b0;
      rise_seen  <= 1'b0;
      echo_start <= '0;
      meas_q     <= 1'b0;
    end else if (ctrl.accept) begin
      prev_echo  <= level;
      rise_seen  <= rise_seen_next;
      echo_start <= echo_start_next;
      meas_q     <= meas_next;
    end
  end

  // duration wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      dur_q <= now_us - echo_start;
    end
  end

  assign prod         = PROD_W'(dur_q[15:0]) * PROD_W'(DIST_MULT);
  assign quot         = prod[DIST_SHIFT +: 17];
  assign out_of_range = (dur_q == '0) || (dur_q > {16'd0, max_echo_us});

  always_comb begin
    if (out_of_range) begin
      new_dist = max_distance;
    end else if (quot[16]) begin
      new_dist = '1;
    end else begin
      new_dist = quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_distance <= MAX_DISTANCE_RESET;
    end else if (ctrl.move && meas_q) begin
      channel_distance <= new_dist;
    end
  end

  assign distance = meas_q ? new_dist : channel_distance;
  assign measured = meas_q;

endmodule

[rtl/core/mcur_merge.sv]
// Output stage: combines lane results into one registered result word.
module mcur_merge import mcur_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  move,
  input  logic                  trig,
  input  logic [MAX_LANES-1:0]  enable,
  input  logic [MAX_LANES-1:0]  measured,
  input  logic [DIST_W-1:0]     lane_dist [MAX_LANES],
  input  logic [DIST_W-1:0]     max_distance,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int PAD_W = OUT_DATA_W - 1 - MAX_LANES - MAX_LANES * DIST_W;

  logic [MAX_LANES*DIST_W-1:0] dist_flat;

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      dist_flat[i*DIST_W +: DIST_W] = enable[i] ? lane_dist[i] : max_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_tdata <= {{PAD_W{1'b0}}, dist_flat, measured & enable, trig};
    end
  end

endmodule

[rtl/core/multi_channel_ultrasonic_ranger.sv]
// Top level of the multi-channel ultrasonic ranger: config registers, lanes and pipeline control.
//
// Usage:
//   Feed one request per microsecond on the s_ group; s_tdata[7:0] carries the echo level of
//   each sensor (bit i is channel i). Every request yields exactly one result on the m_ group:
//   the shared trigger level, a mask of channels that finished a measurement on that tick, and
//   the distance of every channel in 0.01 cm (disabled channels show max_distance).
//   Registers are written through cfg_wr_en / cfg_index / cfg_wdata, one per clock; the user
//   must write them only while the block holds no request in flight; the block does not enforce it.
// Pipeline and throughput:
//   A request accepted into the capture stage moves on to the output register, where m_tvalid
//   and m_tdata present its result. One request is taken every cycle while m_tready does not
//   stall the output; the rate is set by the edge/duration capture stage feeding the per-lane
//   16x29 distance multiplier, both of which finish once per clock.
// Reset:
//   rst (synchronous) clears the time base, the trigger and the edge history, sets every
//   stored distance to 40000 and loads the register reset values; the pipeline comes up empty.
// Backpressure:
//   When m_tready is low the result is held; one more request may enter the capture stage,
//   after which s_tready drops until the result is taken.
module multi_channel_ultrasonic_ranger import mcur_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT,
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: echo_levels[7:0]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // m_tdata: trig_level[0], ready_mask[8:1], distance_0[24:9] .. distance_7[136:121], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg;
  pipe_ctrl_t        ctrl;
  logic              s1_valid;
  logic              out_free;
  logic              trig_next;
  logic              trig_q;
  logic [TIME_W-1:0] now_us;
  logic [MAX_LANES-1:0] enable;
  logic [MAX_LANES-1:0] measured;
  logic [DIST_W-1:0]    lane_dist [MAX_LANES];

  // Configuration registers: write on enable, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_count      <= SENSOR_COUNT_RESET;
      cfg.max_distance      <= MAX_DISTANCE_RESET;
      cfg.burst_interval_ms <= BURST_MS_RESET;
      cfg.max_echo_us       <= MAX_ECHO_RESET;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_SENSOR_COUNT: cfg.sensor_count      <= cfg_wdata[3:0];
        REG_MAX_DISTANCE: cfg.max_distance      <= cfg_wdata;
        REG_BURST_MS:     cfg.burst_interval_ms <= cfg_wdata;
        REG_MAX_ECHO:     cfg.max_echo_us       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: advance the capture stage into the output register whenever it is
  // empty or being drained; accept a new request whenever the capture stage is empty or can hand off.
  assign out_free    = !m_tvalid || m_tready;
  assign ctrl.move   = s1_valid && out_free;
  assign s_tready    = !s1_valid || out_free;
  assign ctrl.accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctrl.accept) begin
      s1_valid <= 1'b1;
    end else if (ctrl.move) begin
      s1_valid <= 1'b0;
    end
  end

  // Hold the trigger level that belongs to the request in the capture stage.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      trig_q <= trig_next;
    end
  end

  // Channel i is enabled when it lies below sensor_count; lanes past NUM_CHANNELS don't exist.
  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      enable[i] = (i < NUM_CHANNELS) && (cfg.sensor_count > 4'(i));
    end
  end

  mcur_timer #(
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_timer (
    .clk               (clk),
    .rst               (rst),
    .accept            (ctrl.accept),
    .run               (cfg.sensor_count != 4'd0),
    .burst_interval_ms (cfg.burst_interval_ms),
    .now_us            (now_us),
    .trig_next         (trig_next)
  );

  for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
    if (g < NUM_CHANNELS) begin : g_on
      mcur_lane u_lane (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .level        (s_tdata[g]),
        .enable       (enable[g]),
        .now_us       (now_us),
        .max_distance (cfg.max_distance),
        .max_echo_us  (cfg.max_echo_us),
        .distance     (lane_dist[g]),
        .measured     (measured[g])
      );
    end else begin : g_off
      // No lane here: report max_distance and never flag a measurement.
      assign lane_dist[g] = cfg.max_distance;
      assign measured[g]  = 1'b0;
    end
  end

  mcur_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .move         (ctrl.move),
    .trig         (trig_q),
    .enable       (enable),
    .measured     (measured),
    .lane_dist    (lane_dist),
    .max_distance (cfg.max_distance),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata)
  );

endmodule

[tb/ranger_checker.sv]
`timescale 1ns / 100ps
// Checker for the multi-channel ultrasonic ranger: predicts every tick result and compares it.
module ranger_checker import mcur_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    errors
);

  typedef struct packed {
    logic [7:0][DIST_W-1:0] distance;
    logic [7:0]             ready;
    logic                   trig;
  } tick_result_t;

  // register copies
  logic [3:0]        sensor_cnt;
  logic [DIST_W-1:0] far_dist;
  logic [15:0]       burst_ms;
  logic [15:0]       echo_limit_us;

  // time base, trigger and per-channel capture state
  logic [TIME_W-1:0] us_clock, ms_clock, trig_start_us, trig_end_ms;
  logic [9:0]        ms_div;
  logic              trig_on;
  logic [7:0]        echo_prev, rise_armed;
  logic [TIME_W-1:0] rise_us [8];
  logic [DIST_W-1:0] dist_store [8];

  tick_result_t predicted_ticks [$];
  tick_result_t want, got;

  function automatic logic [DIST_W-1:0] echo_distance(input logic [TIME_W-1:0] dur);
    logic [63:0] prod;
    if (dur == '0 || dur > {16'd0, echo_limit_us}) return far_dist;
    prod = ({32'd0, dur} * 64'd1715) / 64'd1000;
    if (prod > 64'd65535) return 16'hFFFF;
    return prod[DIST_W-1:0];
  endfunction

  task automatic range_tick(input logic [7:0] lv, output tick_result_t r);
    int unsigned n;
    int i;
    n = (sensor_cnt > NUM_CHANNELS_DEFAULT) ? NUM_CHANNELS_DEFAULT : sensor_cnt;
    r = '0;
    for (i = 0; i < 8; i++) begin
      if (i < n && lv[i] != echo_prev[i]) begin
        if (lv[i]) begin
          rise_us[i]    = us_clock;
          rise_armed[i] = 1'b1;
        end else if (rise_armed[i]) begin
          dist_store[i] = echo_distance(us_clock - rise_us[i]);
          rise_armed[i] = 1'b0;
          r.ready[i]    = 1'b1;
        end
      end
    end
    echo_prev = lv;
    if (n != 0) begin
      if (!trig_on) begin
        if (ms_clock - trig_end_ms >= {16'd0, burst_ms}) begin
          trig_on       = 1'b1;
          trig_start_us = us_clock;
        end
      end else if (us_clock - trig_start_us >= PULSE_US) begin
        trig_on     = 1'b0;
        trig_end_ms = ms_clock;
      end
    end
    r.trig = trig_on;
    for (i = 0; i < 8; i++) r.distance[i] = (i < n) ? dist_store[i] : far_dist;
    us_clock = us_clock + 1;
    ms_div   = ms_div + 10'd1;
    if (ms_div >= TICKS_PER_MS_DEFAULT) begin
      ms_div   = '0;
      ms_clock = ms_clock + 1;
    end
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sensor_cnt    = SENSOR_COUNT_RESET;
      far_dist      = MAX_DISTANCE_RESET;
      burst_ms      = BURST_MS_RESET;
      echo_limit_us = MAX_ECHO_RESET;
      us_clock      = '0;
      ms_clock      = '0;
      ms_div        = '0;
      trig_on       = 1'b0;
      trig_start_us = '0;
      trig_end_ms   = '0;
      echo_prev     = '0;
      rise_armed    = '0;
      for (int i = 0; i < 8; i++) begin
        rise_us[i]    = '0;
        dist_store[i] = MAX_DISTANCE_RESET;
      end
      predicted_ticks.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (reg_index_t'(cfg_index))
          REG_SENSOR_COUNT: sensor_cnt    = cfg_wdata[3:0];
          REG_MAX_DISTANCE: far_dist      = cfg_wdata[DIST_W-1:0];
          REG_BURST_MS:     burst_ms      = cfg_wdata[15:0];
          REG_MAX_ECHO:     echo_limit_us = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (predicted_ticks.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
          errors++;
        end else begin
          want       = predicted_ticks.pop_front();
          got.trig   = m_tdata[0];
          got.ready  = m_tdata[8:1];
          for (int i = 0; i < 8; i++) got.distance[i] = m_tdata[9 + 16*i +: 16];
          if (got.trig != want.trig) report("trig_level", want.trig, got.trig);
          if (got.ready != want.ready) report("ready_mask", want.ready, got.ready);
          for (int i = 0; i < 8; i++)
            if (got.distance[i] != want.distance[i])
              report($sformatf("distance_%0d", i), want.distance[i], got.distance[i]);
          if (m_tdata[OUT_DATA_W-1:137] != '0)
            report("pad", 0, m_tdata[OUT_DATA_W-1:137]);
        end
      end
      if (s_tvalid && s_tready) begin
        range_tick(s_tdata, want);
        predicted_ticks.push_back(want);
      end
    end
    pending = predicted_ticks.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the multi-channel ultrasonic ranger: stimulus, handshake idling and verdict.
module tb;
  import mcur_pkg::*;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int pending, errors;

  // idle rates in percent: gaps on the request side, stalls on the result side
  int tx_gap_pct, rx_idle_pct;

  // echo waveform generator: level and remaining hold time per channel
  logic [7:0] wave_lvl;
  int         hold_left [8];

  multi_channel_ultrasonic_ranger dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ranger_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Stall the result side at random; a rate of zero keeps m_tready high.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Send one tick request. Called at a falling edge, returns at a falling edge;
  // valid stays high on return so back-to-back ticks need no extra assignment.
  task automatic send_tick(input logic [7:0] lv);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= lv;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register once the block has drained every request.
  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle(input int gap_pct, input int stall_pct);
    tx_gap_pct  = gap_pct;
    rx_idle_pct = stall_pct;
  endtask

  // Advance the echo waveform: each channel toggles after a random hold, so echoes
  // of many lengths come out; one tick in ten is replaced by a random byte.
  task automatic next_levels(input int hold_max, output logic [7:0] lv);
    for (int i = 0; i < 8; i++) begin
      if (hold_left[i] <= 0) begin
        wave_lvl[i]  = ~wave_lvl[i];
        hold_left[i] = $urandom_range(1, hold_max);
      end
      hold_left[i]--;
    end
    lv = ($urandom_range(0, 9) == 0) ? 8'($urandom) : wave_lvl;
  endtask

  initial begin
    logic [7:0] lv;
    int         hold_max;
    int         k;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    wave_lvl  = '0;
    for (int i = 0; i < 8; i++) hold_left[i] = 0;
    set_idle(12, 75);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: after reset no channel is enabled; edges must be ignored, the
    // trigger must stay low and every distance must read the reset far value.
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h3C);
    send_tick(8'hFF);

    // Enable all channels while every echo is high: the next fall has no rise.
    write_reg(REG_SENSOR_COUNT, 16'd8);
    write_reg(REG_MAX_DISTANCE, 16'hFFFF);
    write_reg(REG_BURST_MS, 16'd0);
    write_reg(REG_MAX_ECHO, 16'd2);
    send_tick(8'h00);
    // shortest echo, then interleaved two-tick echoes on odd and even channels
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h55);
    send_tick(8'hFF);
    send_tick(8'hAA);
    send_tick(8'h00);
    // three-tick echo runs past the limit of two
    send_tick(8'h0F);
    send_tick(8'h0F);
    send_tick(8'h0F);
    send_tick(8'h00);

    // Count above the channel number, far value of zero, widest echo limit.
    write_reg(REG_MAX_ECHO, 16'hFFFF);
    write_reg(REG_SENSOR_COUNT, 16'd15);
    write_reg(REG_MAX_DISTANCE, 16'd0);
    send_tick(8'hF0);
    send_tick(8'h00);

    // Only three channels enabled: the rest must report the far value.
    write_reg(REG_SENSOR_COUNT, 16'd3);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h00);

    // Random phases: echo trains with some random ticks under a new setting each time,
    // extremes first, then random settings.
    for (int p = 0; p < 12; p++) begin
      if (p < 4) set_idle(12, 75);
      else if (p < 8) set_idle(75, 12);
      else set_idle(0, 0);
      case (p)
        0: begin
          write_reg(REG_SENSOR_COUNT, 16'd8);
          write_reg(REG_MAX_DISTANCE, 16'd40000);
          write_reg(REG_BURST_MS, 16'd0);
          write_reg(REG_MAX_ECHO, 16'd40);
          hold_max = 60;
        end
        1: begin
          write_reg(REG_SENSOR_COUNT, 16'd5);
          write_reg(REG_MAX_DISTANCE, 16'd0);
          write_reg(REG_BURST_MS, 16'd0);
          write_reg(REG_MAX_ECHO, 16'hFFFF);
          hold_max = 20;
        end
        2: begin
          write_reg(REG_SENSOR_COUNT, 16'd1);
          write_reg(REG_MAX_DISTANCE, 16'($urandom));
          write_reg(REG_BURST_MS, 16'd1);
          write_reg(REG_MAX_ECHO, 16'd10);
          hold_max = 15;
        end
        3: begin
          write_reg(REG_SENSOR_COUNT, 16'd15);
          write_reg(REG_MAX_DISTANCE, 16'hFFFF);
          write_reg(REG_BURST_MS, 16'd0);
          write_reg(REG_MAX_ECHO, 16'd25);
          hold_max = 40;
        end
        4: begin
          // trigger must hold whatever level it had
          write_reg(REG_SENSOR_COUNT, 16'd0);
          write_reg(REG_MAX_DISTANCE, 16'd1234);
          write_reg(REG_BURST_MS, 16'hFFFF);
          write_reg(REG_MAX_ECHO, 16'd30);
          hold_max = 30;
        end
        5: begin
          // every echo is too long for a limit of zero
          write_reg(REG_SENSOR_COUNT, 16'd7);
          write_reg(REG_MAX_DISTANCE, 16'd500);
          write_reg(REG_BURST_MS, 16'hFFFF);
          write_reg(REG_MAX_ECHO, 16'd0);
          hold_max = 12;
        end
        default: begin
          write_reg(REG_SENSOR_COUNT, 16'($urandom_range(0, 15)));
          write_reg(REG_MAX_DISTANCE, 16'($urandom));
          write_reg(REG_BURST_MS, 16'($urandom_range(0, 2)));
          write_reg(REG_MAX_ECHO, 16'($urandom_range(1, 80)));
          hold_max = $urandom_range(4, 60);
        end
      endcase
      for (k = 0; k < 70; k++) begin
        next_levels(hold_max, lv);
        send_tick(lv);
      end
    end

    // Longer echoes on two channels while the trigger repeats on a zero interval.
    write_reg(REG_SENSOR_COUNT, 16'd2);
    write_reg(REG_MAX_DISTANCE, 16'($urandom));
    write_reg(REG_BURST_MS, 16'd0);
    write_reg(REG_MAX_ECHO, 16'hFFFF);
    for (k = 0; k <= 90; k++) begin
      lv[7:2] = 6'($urandom);
      lv[0]   = (k > 0 && k < 90);
      lv[1]   = (k > 0 && k < 61);
      send_tick(lv);
    end

    // Drain, then allow the pipeline depth before the verdict.
    s_tvalid <= 1'b0;
    for (k = 0; k < 100000 && pending != 0; k++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
